### rtl/gwc_pkg.sv
package gwc_pkg;

   localparam int PIXEL_W     = 8;
   localparam int COORD_W     = 10;
   localparam int DIM_W       = 11;
   localparam int WEIGHT_W    = 6;
   localparam int SUM_W       = 19;
   localparam int KERNEL_SIZE = 5;
   localparam int LINES       = KERNEL_SIZE - 1;
   localparam int CENTRE_OFS  = KERNEL_SIZE / 2;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int LINE_ADDR_W = $clog2(MAX_WIDTH);
   localparam int CSR_INDEX_W = 3;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = ((SUM_W + 2 * COORD_W + 7) / 8) * 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_W_CORNER       = 3'd2,
      CSR_W_NEAR_CORNER  = 3'd3,
      CSR_W_OUTER_MIDDLE = 3'd4,
      CSR_W_INNER_DIAG   = 3'd5,
      CSR_W_INNER_STRAIT = 3'd6,
      CSR_W_CENTRE       = 3'd7
   } gwc_csr_type;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [KERNEL_SIZE-1:0][PIXEL_W-1:0] gwc_column_type;
   typedef logic [LINES-1:0][PIXEL_W-1:0] gwc_word_type;
   typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIXEL_W-1:0] gwc_window_type;

   typedef struct packed {
      logic               emit;
      logic               last;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } gwc_meta_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] corner;
      logic [WEIGHT_W-1:0] near_corner;
      logic [WEIGHT_W-1:0] outer_middle;
      logic [WEIGHT_W-1:0] inner_diag;
      logic [WEIGHT_W-1:0] inner_straight;
      logic [WEIGHT_W-1:0] centre;
   } gwc_weights_type;

   typedef struct packed {
      logic [PIXEL_W+1:0] corner;
      logic [PIXEL_W+2:0] near_corner;
      logic [PIXEL_W+1:0] outer_middle;
      logic [PIXEL_W+1:0] inner_diag;
      logic [PIXEL_W+1:0] inner_straight;
      logic [PIXEL_W-1:0] centre;
   } gwc_sums_type;

   typedef struct packed {
      logic [PIXEL_W+WEIGHT_W+1:0] corner;
      logic [PIXEL_W+WEIGHT_W+2:0] near_corner;
      logic [PIXEL_W+WEIGHT_W+1:0] outer_middle;
      logic [PIXEL_W+WEIGHT_W+1:0] inner_diag;
      logic [PIXEL_W+WEIGHT_W+1:0] inner_straight;
      logic [PIXEL_W+WEIGHT_W-1:0] centre;
   } gwc_prod_type;

endpackage

### rtl/gaussian_5x5_window_convolver.sv
// 5x5 weighted window filter for 8-bit grey pixels in raster order. One pixel is
// taken per clock; a result passes the line-buffer, window, sum, product and output
// registers for every pixel at least two rows and two columns from the image edge
// (none for the border). Four previous rows live in a 1024 x 32-bit line memory
// with one read and one write port; the weighted sum is exact (divide by the sum of
// the weights, 273 at reset, for the smoothed value). Input stalls only while a
// result sits unaccepted in the output register and another is ready behind it.
// start_of_frame restarts the position at row 0, column 0. Write geometry and
// weights only while the block is idle.
module gaussian_5x5_window_convolver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gwc_pkg::REQ_DATA_W-1:0]      req_tdata,  // [7:0] pixel
   input  logic                                req_tuser,  // [0] start_of_frame
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gwc_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [18:0] weighted_sum,
                                                           // [28:19] centre_row,
                                                           // [38:29] centre_col
   output logic                                rsp_tlast,  // last_of_frame
   input  logic                                csr_we,
   input  logic [gwc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gwc_pkg::DIM_W-1:0]           csr_wdata
);
   import gwc_pkg::*;

   logic [DIM_W-1:0]    width_ff;
   logic [DIM_W-1:0]    height_ff;
   gwc_weights_type     weights_ff;
   logic [COORD_W-1:0]  row_ff;
   logic [COORD_W-1:0]  col_ff;
   logic [COORD_W-1:0]  row_in;
   logic [COORD_W-1:0]  col_in;
   logic [DIM_W-1:0]    w_eff;
   logic [DIM_W-1:0]    h_eff;
   logic [DIM_W-1:0]    cur_row;
   logic [DIM_W-1:0]    cur_col;
   logic [DIM_W-1:0]    row_plus;
   logic [DIM_W-1:0]    col_plus;
   logic                adv;
   logic                accept;
   gwc_meta_type        in_meta;
   logic                col_valid;
   gwc_column_type      column;
   gwc_meta_type        col_meta;
   logic                sums_valid;
   gwc_sums_type        sums;
   gwc_meta_type        sums_meta;
   logic                prod_valid;
   gwc_meta_type        prod_meta;
   logic [SUM_W-1:0]    total;
   logic                rsp_valid_ff;
   logic [SUM_W-1:0]    rsp_sum_ff;
   logic [COORD_W-1:0]  rsp_row_ff;
   logic [COORD_W-1:0]  rsp_col_ff;
   logic                rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff                  <= DIM_W'(640);
         height_ff                 <= DIM_W'(480);
         weights_ff.corner         <= WEIGHT_W'(1);
         weights_ff.near_corner    <= WEIGHT_W'(4);
         weights_ff.outer_middle   <= WEIGHT_W'(7);
         weights_ff.inner_diag     <= WEIGHT_W'(16);
         weights_ff.inner_straight <= WEIGHT_W'(26);
         weights_ff.centre         <= WEIGHT_W'(41);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    width_ff                  <= csr_wdata;
            CSR_IMAGE_HEIGHT:   height_ff                 <= csr_wdata;
            CSR_W_CORNER:       weights_ff.corner         <= csr_wdata[WEIGHT_W-1:0];
            CSR_W_NEAR_CORNER:  weights_ff.near_corner    <= csr_wdata[WEIGHT_W-1:0];
            CSR_W_OUTER_MIDDLE: weights_ff.outer_middle   <= csr_wdata[WEIGHT_W-1:0];
            CSR_W_INNER_DIAG:   weights_ff.inner_diag     <= csr_wdata[WEIGHT_W-1:0];
            CSR_W_INNER_STRAIT: weights_ff.inner_straight <= csr_wdata[WEIGHT_W-1:0];
            CSR_W_CENTRE:       weights_ff.centre         <= csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end
      h_eff = height_ff;
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (height_ff > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end
   end

   assign adv        = !prod_valid || !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   always_comb begin
      cur_row = {1'b0, row_ff};
      cur_col = {1'b0, col_ff};
      if (req_tuser) begin
         cur_row = '0;
         cur_col = '0;
      end
      // wrap a position left out of bounds by a geometry change
      if (cur_col >= w_eff) begin
         cur_col = '0;
         cur_row = cur_row + DIM_W'(1);
      end
      if (cur_row >= h_eff) begin
         cur_row = '0;
      end
      row_plus = cur_row + DIM_W'(1);
      col_plus = cur_col + DIM_W'(1);

      in_meta.row  = cur_row[COORD_W-1:0];
      in_meta.col  = cur_col[COORD_W-1:0];
      in_meta.emit = (cur_row >= DIM_W'(LINES)) && (cur_col >= DIM_W'(LINES));
      in_meta.last = (row_plus >= h_eff) && (col_plus >= w_eff);

      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_plus >= w_eff) begin
            col_in = '0;
            row_in = (row_plus >= h_eff) ? '0 : row_plus[COORD_W-1:0];
         end else begin
            col_in = col_plus[COORD_W-1:0];
            row_in = cur_row[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   gwc_line_buffer u_line_buffer (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (accept),
      .in_px     (req_tdata[PIXEL_W-1:0]),
      .in_meta   (in_meta),
      .col_valid (col_valid),
      .column    (column),
      .col_meta  (col_meta)
   );

   gwc_window u_window (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .col_valid  (col_valid),
      .column     (column),
      .col_meta   (col_meta),
      .sums_valid (sums_valid),
      .sums       (sums),
      .sums_meta  (sums_meta)
   );

   gwc_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .sums_valid (sums_valid),
      .sums       (sums),
      .sums_meta  (sums_meta),
      .weights    (weights_ff),
      .prod_valid (prod_valid),
      .prod_meta  (prod_meta),
      .total      (total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && prod_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && prod_valid) begin
         rsp_sum_ff  <= total;
         rsp_row_ff  <= prod_meta.row - COORD_W'(CENTRE_OFS);
         rsp_col_ff  <= prod_meta.col - COORD_W'(CENTRE_OFS);
         rsp_last_ff <= prod_meta.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SUM_W - 2 * COORD_W)'(0),
                        rsp_col_ff, rsp_row_ff, rsp_sum_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/gwc_line_buffer.sv
module gwc_line_buffer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  gwc_pkg::pixel_type            in_px,
   input  gwc_pkg::gwc_meta_type         in_meta,
   output logic                          col_valid,
   output gwc_pkg::gwc_column_type       column,
   output gwc_pkg::gwc_meta_type         col_meta
);
   import gwc_pkg::*;

   gwc_word_type              line_mem [MAX_WIDTH];
   gwc_word_type              rd_word_ff;
   gwc_word_type              old_word;
   gwc_word_type              new_word;
   logic                      s1_valid_ff;
   pixel_type                 s1_px_ff;
   gwc_meta_type              s1_meta_ff;
   logic                      fwd_valid_ff;
   logic [LINE_ADDR_W-1:0]    fwd_addr_ff;
   gwc_word_type              fwd_word_ff;
   logic [LINE_ADDR_W-1:0]    rd_addr;
   logic [LINE_ADDR_W-1:0]    s1_addr;

   assign rd_addr = in_meta.col[LINE_ADDR_W-1:0];
   assign s1_addr = s1_meta_ff.col[LINE_ADDR_W-1:0];

   // take the word just written when the same column comes back next cycle
   assign old_word = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_word_ff : rd_word_ff;

   always_comb begin
      for (int r = 0; r < LINES; r++) begin
         column[r] = old_word[r];
      end
      column[LINES] = s1_px_ff;
      for (int r = 0; r < LINES; r++) begin
         new_word[r] = column[r+1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         line_mem[s1_addr] <= new_word;
      end
      if (adv) begin
         rd_word_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= in_valid;
         fwd_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff    <= in_px;
         s1_meta_ff  <= in_meta;
         fwd_addr_ff <= s1_addr;
         fwd_word_ff <= new_word;
      end
   end

   assign col_valid = s1_valid_ff;
   assign col_meta  = s1_meta_ff;

endmodule

### rtl/gwc_window.sv
module gwc_window (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     col_valid,
   input  gwc_pkg::gwc_column_type  column,
   input  gwc_pkg::gwc_meta_type    col_meta,
   output logic                     sums_valid,
   output gwc_pkg::gwc_sums_type    sums,
   output gwc_pkg::gwc_meta_type    sums_meta
);
   import gwc_pkg::*;

   gwc_window_type  window_ff;
   gwc_window_type  window_in;
   logic            s2_valid_ff;
   gwc_meta_type    s2_meta_ff;
   gwc_sums_type    sums_in;
   gwc_sums_type    sums_ff;
   logic            s3_valid_ff;
   gwc_meta_type    s3_meta_ff;

   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
            window_in[r][c] = window_ff[r][c+1];
         end
         window_in[r][KERNEL_SIZE-1] = column[r];
      end
   end

   // group pixels that share a weight
   always_comb begin
      sums_in.corner = 10'(window_ff[0][0]) + 10'(window_ff[0][4])
                     + 10'(window_ff[4][0]) + 10'(window_ff[4][4]);
      sums_in.near_corner = 11'(window_ff[0][1]) + 11'(window_ff[0][3])
                          + 11'(window_ff[4][1]) + 11'(window_ff[4][3])
                          + 11'(window_ff[1][0]) + 11'(window_ff[3][0])
                          + 11'(window_ff[1][4]) + 11'(window_ff[3][4]);
      sums_in.outer_middle = 10'(window_ff[0][2]) + 10'(window_ff[4][2])
                           + 10'(window_ff[2][0]) + 10'(window_ff[2][4]);
      sums_in.inner_diag = 10'(window_ff[1][1]) + 10'(window_ff[1][3])
                         + 10'(window_ff[3][1]) + 10'(window_ff[3][3]);
      sums_in.inner_straight = 10'(window_ff[1][2]) + 10'(window_ff[3][2])
                             + 10'(window_ff[2][1]) + 10'(window_ff[2][3]);
      sums_in.centre = window_ff[2][2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         if (col_valid) begin
            window_ff <= window_in;
         end
         s2_valid_ff <= col_valid && col_meta.emit;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_meta_ff <= col_meta;
         s3_meta_ff <= s2_meta_ff;
         sums_ff    <= sums_in;
      end
   end

   assign sums_valid = s3_valid_ff;
   assign sums       = sums_ff;
   assign sums_meta  = s3_meta_ff;

endmodule

### rtl/gwc_mac.sv
module gwc_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      sums_valid,
   input  gwc_pkg::gwc_sums_type     sums,
   input  gwc_pkg::gwc_meta_type     sums_meta,
   input  gwc_pkg::gwc_weights_type  weights,
   output logic                      prod_valid,
   output gwc_pkg::gwc_meta_type     prod_meta,
   output logic [gwc_pkg::SUM_W-1:0] total
);
   import gwc_pkg::*;

   gwc_prod_type  prod_in;
   gwc_prod_type  prod_ff;
   logic          s4_valid_ff;
   gwc_meta_type  s4_meta_ff;

   always_comb begin
      prod_in.corner         = $bits(prod_in.corner)'(sums.corner)
                             * $bits(prod_in.corner)'(weights.corner);
      prod_in.near_corner    = $bits(prod_in.near_corner)'(sums.near_corner)
                             * $bits(prod_in.near_corner)'(weights.near_corner);
      prod_in.outer_middle   = $bits(prod_in.outer_middle)'(sums.outer_middle)
                             * $bits(prod_in.outer_middle)'(weights.outer_middle);
      prod_in.inner_diag     = $bits(prod_in.inner_diag)'(sums.inner_diag)
                             * $bits(prod_in.inner_diag)'(weights.inner_diag);
      prod_in.inner_straight = $bits(prod_in.inner_straight)'(sums.inner_straight)
                             * $bits(prod_in.inner_straight)'(weights.inner_straight);
      prod_in.centre         = $bits(prod_in.centre)'(sums.centre)
                             * $bits(prod_in.centre)'(weights.centre);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= sums_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff    <= prod_in;
         s4_meta_ff <= sums_meta;
      end
   end

   assign total = SUM_W'(prod_ff.corner) + SUM_W'(prod_ff.near_corner)
                + SUM_W'(prod_ff.outer_middle) + SUM_W'(prod_ff.inner_diag)
                + SUM_W'(prod_ff.inner_straight) + SUM_W'(prod_ff.centre);

   assign prod_valid = s4_valid_ff;
   assign prod_meta  = s4_meta_ff;

endmodule

### rtl/gwc_checker.sv
module gwc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tready,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [gwc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tlast
);
   import gwc_pkg::*;

   logic [COORD_W-1:0] centre_row;
   logic [COORD_W-1:0] centre_col;

   assign centre_row = rsp_tdata[SUM_W+COORD_W-1:SUM_W];
   assign centre_col = rsp_tdata[SUM_W+2*COORD_W-1:SUM_W+COORD_W];

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // input only backs up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a stalled result");

   // results only for interior pixels
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (centre_row >= COORD_W'(CENTRE_OFS))
                  && (centre_col >= COORD_W'(CENTRE_OFS)))
      else $error("result for a border pixel");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind gaussian_5x5_window_convolver gwc_checker u_gwc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
